// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fixup block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Relocation fixup package
// Item types, location type codes and status codes shared by the fixup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfa_pkg;

	// Target kinds
	localparam logic [1:0] KIND_SEGMENT  = 2'd0;
	localparam logic [1:0] KIND_GROUP    = 2'd1;
	localparam logic [1:0] KIND_EXTERNAL = 2'd2;
	localparam logic [1:0] KIND_NONE     = 2'd3;

	// Location types
	localparam logic [3:0] LOC_LOW_BYTE  = 4'd0;
	localparam logic [3:0] LOC_OFFSET16  = 4'd1;
	localparam logic [3:0] LOC_BASE16    = 4'd2;
	localparam logic [3:0] LOC_FAR_PTR   = 4'd3;
	localparam logic [3:0] LOC_OFFSET16B = 4'd5;

	// Byte counts to store
	localparam logic [2:0] WB_NONE  = 3'd0;
	localparam logic [2:0] WB_BYTE  = 3'd1;
	localparam logic [2:0] WB_WORD  = 3'd2;
	localparam logic [2:0] WB_DWORD = 3'd4;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_SELF_REL   = 2'd1,
		ST_UNHANDLED  = 2'd2,
		ST_UNRESOLVED = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  target_kind;
		logic [15:0] target_base;
		logic [15:0] symbol_offset;
		logic        symbol_found;
		logic [15:0] displacement;
		logic [3:0]  location_type;
		logic        seg_relative;
		logic [15:0] patch_offset;
		logic [31:0] current_value;
	} fixup_t;

	typedef struct packed {
		logic [31:0] new_value;
		logic [2:0]  write_bytes;
		logic        done_res;
		status_t     status;
	} result_t;

	// Target resolution handed from the target module to the patch logic
	typedef struct packed {
		logic [15:0] address;
		logic        unresolved;
	} target_t;

endpackage

// ----- rtl/relocation_fixup_apply_core.sv -----
// ----------------------------------------------------------------------------
// Relocation fixup apply core
// Applies one 16-bit object-file relocation per item. Each fixup item is
// captured in an input register, resolved and patched by combinational logic,
// and the result is held in a result register. Throughput is one item per
// clock while the result side does not stall. An accepted item passes from the
// input register to the result register before it is shown. A stalled result
// does not block acceptance while the input register is free, and both
// registers keep moving whenever the result side takes its item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module relocation_fixup_apply_core import rfa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fixup_valid,
	output logic    fixup_stall,
	input  fixup_t  fixup,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic    valid_s1;
	fixup_t  item_s1;
	logic    valid_s2;
	result_t result_s2;
	logic    load_s1;
	logic    load_s2;
	target_t target;
	result_t patched;

	// Pipeline advance
	assign load_s2     = !valid_s2 || !result_stall;
	assign load_s1     = !valid_s1 || load_s2;
	assign fixup_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= fixup_valid;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load_s1 && fixup_valid) item_s1 <= fixup;
		if (load_s2 && valid_s1) result_s2 <= patched;
	end

	rfa_target u_target (
		.item   (item_s1),
		.target (target)
	);

	rfa_patch u_patch (
		.item   (item_s1),
		.target (target),
		.result (patched)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// ----- rtl/rfa_target.sv -----
// ----------------------------------------------------------------------------
// Fixup target address
// Forms the 16-bit target address from kind, base, symbol offset and
// displacement, and flags an unresolved external symbol.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfa_target import rfa_pkg::*; (
	input  fixup_t  item,
	output target_t target
);

	logic [15:0] frame;

	// Base of the target frame; no target means base zero
	always_comb begin
		case (item.target_kind)
			KIND_SEGMENT, KIND_GROUP: frame = item.target_base;
			KIND_EXTERNAL:            frame = item.target_base + item.symbol_offset;
			default:                  frame = 16'd0;
		endcase
	end

	// Displacement wraps in 16 bits
	assign target.address    = frame + item.displacement;
	assign target.unresolved = (item.target_kind == KIND_EXTERNAL) && !item.symbol_found;

endmodule

// ----- rtl/rfa_patch.sv -----
// ----------------------------------------------------------------------------
// Fixup patch value
// Combines the target with the stored word per location type and mode, and
// produces the value, byte count, done flag and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfa_patch import rfa_pkg::*; (
	input  fixup_t  item,
	input  target_t target,
	output result_t result
);

	logic [7:0]  byte_seg;
	logic [7:0]  byte_self;
	logic [15:0] word_seg;
	logic [15:0] word_self;
	logic [15:0] base_sum;
	logic [16:0] far_lo;
	logic [3:0]  far_hi;

	// Candidate values for each location type
	assign byte_seg  = target.address[7:0] + item.current_value[7:0];
	assign byte_self = target.address[7:0] - (item.patch_offset[7:0] + 8'd1);
	assign word_seg  = target.address + item.current_value[15:0];
	assign word_self = target.address - (item.patch_offset + 16'd2);
	assign base_sum  = target.address + {item.current_value[11:0], 4'b0000};
	assign far_lo    = {1'b0, target.address} + {1'b0, item.current_value[15:0]};
	// Only bits 19:16 of the upper half survive the 12-bit shift
	assign far_hi    = item.current_value[19:16] + {3'b000, far_lo[16]};

	// Select by location type and relative mode
	always_comb begin
		result = '{new_value: 32'd0, write_bytes: WB_NONE, done_res: 1'b0,
			status: ST_OK};
		if (target.unresolved) begin
			result.status = ST_UNRESOLVED;
		end else begin
			case (item.location_type)
				LOC_LOW_BYTE: begin
					result.new_value   = {24'd0,
						item.seg_relative ? byte_seg : byte_self};
					result.write_bytes = WB_BYTE;
					result.done_res    = 1'b1;
				end
				LOC_OFFSET16, LOC_OFFSET16B: begin
					result.new_value   = {16'd0,
						item.seg_relative ? word_seg : word_self};
					result.write_bytes = WB_WORD;
					result.done_res    = 1'b1;
				end
				LOC_BASE16: begin
					if (item.seg_relative) begin
						result.new_value   = {20'd0, base_sum[15:4]};
						result.write_bytes = WB_WORD;
						result.done_res    = 1'b1;
					end else begin
						result.status = ST_SELF_REL;
					end
				end
				LOC_FAR_PTR: begin
					if (item.seg_relative) begin
						result.new_value   = {far_hi, 12'd0, far_lo[15:0]};
						result.write_bytes = WB_DWORD;
						result.done_res    = 1'b1;
					end else begin
						result.status = ST_SELF_REL;
					end
				end
				default: begin
					result.done_res = 1'b1;
					result.status   = ST_UNHANDLED;
				end
			endcase
		end
	end

endmodule

// ----- rtl/rfa_checker.sv -----
// ----------------------------------------------------------------------------
// Relocation fixup checker
// Port-level assertions on the fixup and result channels, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfa_checker import rfa_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    fixup_valid,
	input logic    fixup_stall,
	input fixup_t  fixup,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A stalled input item stays put
	`ASSERT_NEXT(a_in_hold, clk, arst_n, fixup_valid && fixup_stall, fixup_valid && $stable(fixup), "stalled input item changed")

	// A stalled result item stays put
	`ASSERT_NEXT(a_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result item changed")

	// A successful fixup always writes bytes
	`ASSERT_IMPLY(a_ok_writes, clk, arst_n, result_valid && result.status == ST_OK, result.write_bytes != WB_NONE, "ok item writes no bytes")

	// Nothing to write means a zero value
	`ASSERT_IMPLY(a_none_zero, clk, arst_n, result_valid && result.write_bytes == WB_NONE, result.new_value == 32'd0, "value without bytes to write")

	// Incomplete fixups only for self-relative or unresolved cases
	`ASSERT_IMPLY(a_not_done, clk, arst_n, result_valid && !result.done_res, result.status == ST_SELF_REL || result.status == ST_UNRESOLVED, "incomplete item with bad status")

endmodule

bind relocation_fixup_apply_core rfa_checker u_rfa_checker (.*);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Relocation fixup apply core testbench
// Drives fixup items through the valid/stall handshake. Each accepted item is
// predicted in a small scoreboard class and each returned result is compared
// field by field, in order. The run uses directed corner items first, then
// random items. Both sides idle at random, the result side holds off for a
// long stretch once, and the sender lets the block drain midway and at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import rfa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_WAIT  = 10;

	// Expected patch results and the predictor that fills them
	class fixup_scoreboard;
		result_t expected_q[$];
		int      errors;
		int      checked;

		function result_t predict_patch(fixup_t f);
			result_t     r;
			logic [15:0] t16;
			logic [31:0] tgt;
			logic [31:0] v;
			r.new_value   = '0;
			r.write_bytes = WB_NONE;
			r.done_res    = 1'b0;
			r.status      = ST_OK;
			if (f.target_kind == KIND_EXTERNAL && !f.symbol_found) begin
				r.status = ST_UNRESOLVED;
				return r;
			end
			// 16-bit target address, wraps
			case (f.target_kind)
				KIND_SEGMENT, KIND_GROUP: t16 = f.target_base;
				KIND_EXTERNAL: t16 = f.target_base + f.symbol_offset;
				default: t16 = '0;
			endcase
			t16 = t16 + f.displacement;
			tgt = {16'h0, t16};
			case (f.location_type)
				LOC_LOW_BYTE: begin
					if (f.seg_relative)
						v = tgt + {24'h0, f.current_value[7:0]};
					else
						v = tgt - ({16'h0, f.patch_offset} + 32'd1);
					r.new_value   = {24'h0, v[7:0]};
					r.write_bytes = WB_BYTE;
					r.done_res    = 1'b1;
				end
				LOC_OFFSET16, LOC_OFFSET16B: begin
					if (f.seg_relative)
						v = tgt + {16'h0, f.current_value[15:0]};
					else
						v = tgt - ({16'h0, f.patch_offset} + 32'd2);
					r.new_value   = {16'h0, v[15:0]};
					r.write_bytes = WB_WORD;
					r.done_res    = 1'b1;
				end
				LOC_BASE16: begin
					if (!f.seg_relative) begin
						r.status = ST_SELF_REL;
					end else begin
						v = tgt + ({16'h0, f.current_value[15:0]} << 4);
						r.new_value   = {20'h0, v[15:4]};
						r.write_bytes = WB_WORD;
						r.done_res    = 1'b1;
					end
				end
				LOC_FAR_PTR: begin
					if (!f.seg_relative) begin
						r.status = ST_SELF_REL;
					end else begin
						v = tgt + f.current_value;
						// upper half shifted left by 12 bits
						r.new_value   = ((v & 32'hFFFF_0000) << 12) | (v & 32'h0000_FFFF);
						r.write_bytes = WB_DWORD;
						r.done_res    = 1'b1;
					end
				end
				default: begin
					r.done_res = 1'b1;
					r.status   = ST_UNHANDLED;
				end
			endcase
			return r;
		endfunction

		function void note_fixup(fixup_t f);
			expected_q.push_back(predict_patch(f));
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, new_value %h", $time, got.new_value);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			checked++;
			if (got.new_value !== exp.new_value) begin
				$display("%0t: new_value expected %h got %h", $time,
					exp.new_value, got.new_value);
				errors++;
			end
			if (got.write_bytes !== exp.write_bytes) begin
				$display("%0t: write_bytes expected %0d got %0d", $time,
					exp.write_bytes, got.write_bytes);
				errors++;
			end
			if (got.done_res !== exp.done_res) begin
				$display("%0t: done_res expected %0d got %0d", $time,
					exp.done_res, got.done_res);
				errors++;
			end
			if (got.status !== exp.status) begin
				$display("%0t: status expected %0d got %0d", $time,
					exp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    fixup_valid = 1'b0;
	logic    fixup_stall;
	fixup_t  fixup = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	fixup_scoreboard sb = new;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit long_hold_req = 1'b0;
	int sent_count = 0;
	int cycle_count = 0;

	relocation_fixup_apply_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.fixup_valid  (fixup_valid),
		.fixup_stall  (fixup_stall),
		.fixup        (fixup),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #2 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, sb.expected_q.size());
			$display("[relocation_fixup_apply_core] ERROR");
			$finish;
		end
	end

	function automatic fixup_t mk_fixup(logic [1:0] kind, logic [15:0] base,
			logic [15:0] sym, logic found, logic [15:0] disp, logic [3:0] loc,
			logic seg, logic [15:0] patch, logic [31:0] cur);
		fixup_t f;
		f.target_kind   = kind;
		f.target_base   = base;
		f.symbol_offset = sym;
		f.symbol_found  = found;
		f.displacement  = disp;
		f.location_type = loc;
		f.seg_relative  = seg;
		f.patch_offset  = patch;
		f.current_value = cur;
		return f;
	endfunction

	// Address fields lean toward the wrap points
	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly handled location types and resolved symbols, some of everything else
	function automatic fixup_t rand_fixup();
		fixup_t f;
		f.target_kind   = 2'($urandom_range(0, 3));
		f.target_base   = pick16();
		f.symbol_offset = pick16();
		f.symbol_found  = ($urandom_range(0, 99) < 85);
		f.displacement  = pick16();
		if ($urandom_range(0, 9) < 8) begin
			case ($urandom_range(0, 4))
				0: f.location_type = LOC_LOW_BYTE;
				1: f.location_type = LOC_OFFSET16;
				2: f.location_type = LOC_BASE16;
				3: f.location_type = LOC_FAR_PTR;
				default: f.location_type = LOC_OFFSET16B;
			endcase
		end else begin
			f.location_type = 4'($urandom_range(0, 15));
		end
		f.seg_relative  = ($urandom_range(0, 3) != 0);
		f.patch_offset  = pick16();
		f.current_value = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
		return f;
	endfunction

	function automatic int tx_gap();
		return tx_idle ? $urandom_range(0, 13) : 0;
	endfunction

	// Offer one item; valid stays high into the next item when the gap is zero
	task automatic send_fixup(fixup_t f, int gap);
		if (gap > 0) begin
			fixup_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		fixup_valid <= 1'b1;
		fixup       <= f;
		do @(posedge clk); while (fixup_stall);
		sb.note_fixup(f);
		sent_count++;
	endtask

	task automatic send_random(int count);
		repeat (count) send_fixup(rand_fixup(), tx_gap());
	endtask

	task automatic wait_drain();
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	// Result side: random hold-off per item, one long hold on request
	initial begin
		int wait_cycles;
		wait (arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				wait_cycles = LONG_HOLD;
			end else begin
				wait_cycles = rx_idle ? $urandom_range(0, 13) : 0;
			end
			if (wait_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!result_valid);
			sb.check_result(result);
		end
	end

	// Stimulus
	initial begin
		fixup_t directed_q[$];
		int     i;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner items: every location type with the kinds in turn, extremes alternating
		for (i = 0; i < 16; i++)
			directed_q.push_back(mk_fixup(i[1:0], i[0] ? 16'hFFFF : 16'h0000,
				i[1] ? 16'hFFFF : 16'h0001, 1'b1, i[0] ? 16'hFFFF : 16'h0000,
				i[3:0], 1'b1, i[1] ? 16'hFFFF : 16'h0000,
				i[0] ? 32'hFFFF_FFFF : 32'h0000_0000));
		// self-relative byte and word with the patch offset at the top
		directed_q.push_back(mk_fixup(KIND_GROUP, 16'h0000, 16'h0000, 1'b0, 16'h0000,
			LOC_LOW_BYTE, 1'b0, 16'hFFFF, 32'hFFFF_FFFF));
		directed_q.push_back(mk_fixup(KIND_SEGMENT, 16'h1234, 16'hFFFF, 1'b0, 16'h0010,
			LOC_OFFSET16, 1'b0, 16'hFFFF, 32'h0000_0000));
		// external symbol: resolved with wrap, then unresolved
		directed_q.push_back(mk_fixup(KIND_EXTERNAL, 16'hFFF0, 16'h0020, 1'b1, 16'hFFFF,
			LOC_OFFSET16B, 1'b1, 16'h0100, 32'h8000_FFFF));
		directed_q.push_back(mk_fixup(KIND_EXTERNAL, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF,
			LOC_FAR_PTR, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
		// self-relative base and far pointer are refused
		directed_q.push_back(mk_fixup(KIND_SEGMENT, 16'hFFFF, 16'h0000, 1'b0, 16'h0000,
			LOC_BASE16, 1'b0, 16'h0000, 32'hFFFF_FFFF));
		directed_q.push_back(mk_fixup(KIND_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF,
			LOC_FAR_PTR, 1'b0, 16'hFFFF, 32'hFFFF_FFFF));
		// far pointer with the target address wrapping to zero, base with no target
		directed_q.push_back(mk_fixup(KIND_SEGMENT, 16'hFFFF, 16'h0000, 1'b0, 16'h0001,
			LOC_FAR_PTR, 1'b1, 16'h0000, 32'h000F_FFFF));
		directed_q.push_back(mk_fixup(KIND_NONE, 16'hABCD, 16'h5555, 1'b0, 16'h0000,
			LOC_BASE16, 1'b1, 16'h0000, 32'h0000_0FFF));
		foreach (directed_q[j])
			send_fixup(directed_q[j], tx_gap());

		send_random(400);

		// back to back on both sides
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_random(200);

		// result side holds off while items keep coming
		long_hold_req = 1'b1;
		send_random(100);
		tx_idle = 1'b1;
		rx_idle = 1'b1;

		// sender pauses until the block is empty
		fixup_valid <= 1'b0;
		wait_drain();
		send_random(750);

		fixup_valid <= 1'b0;
		wait_drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Applied %0d fixups, %0d results compared: all target kinds and location",
			sent_count, sb.checked);
		$display("types, unresolved and refused cases, idle gaps, back-to-back and a long hold.");
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("[relocation_fixup_apply_core] OK");
		else
			$display("[relocation_fixup_apply_core] ERROR");
		$finish;
	end

endmodule
